[hdl/tvs_pkg.sv]
// ----------------------------------------------------------------------------
// tvs_pkg: shared types and constants of the trilinear voxel sampler
// Holds the fixed field widths, the item and register codes, and the
// per-sample neighbour descriptor that travels down the pipeline.
// ----------------------------------------------------------------------------
package tvs_pkg;

  // Fixed field widths of the item and configuration ports.
  localparam int LEVEL_W   = 8;
  localparam int POS_W     = 15;
  localparam int WIDX_W    = 6;
  localparam int SIZE_W    = 7;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int SAMPLE_W  = 16;

  // The result carries 8 fraction bits and saturates at 255.0.
  localparam int                  OUT_FRAC = 8;
  localparam logic [SAMPLE_W-1:0] OUT_MAX  = 16'd65280;

  // Item kinds.
  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2,
    REG_BOUND  = 2'd3
  } cfg_reg_t;

  // Neighbour descriptor: parity of the base voxel on each axis (bit 0 is x)
  // and, per axis, whether the lower [0] and upper [1] neighbour is inside.
  typedef struct packed {
    logic [2:0] parity;
    logic [1:0] vx;
    logic [1:0] vy;
    logic [1:0] vz;
  } tvs_corner_t;

endpackage

[hdl/trilinear_voxel_sampler_unit.sv]
// ----------------------------------------------------------------------------
// trilinear_voxel_sampler_unit: trilinear voxel sampler, top level
// Usage:
//   An item is taken at each rising edge with start high (busy stays low,
//   so an item may follow in every cycle). A write item (in_kind low) stores
//   in_write_level at (in_write_x, in_write_y, in_write_z); a sample item
//   (in_kind high) returns one interpolated level on out_sample_level with
//   out_valid high for exactly one cycle, after it has passed the decode,
//   bank read, x, y and z blend and output registers. Throughput is one item
//   per cycle: the store is split into eight banks by the parity of x, y and
//   z, so the eight neighbours of a point are read together; the three
//   blends each own a pipeline stage.
//   A write is visible to a sample taken in the next cycle.
//   Registers are written through cfg_we/cfg_index/cfg_data while no sample
//   is in flight. The receiver cannot stall; each result must be taken in its
//   cycle. Reset clears the pipeline and restores the sizes to 64 and the
//   boundary level to 0; the voxel contents are not cleared and must be
//   written before they are sampled.
// ----------------------------------------------------------------------------
module trilinear_voxel_sampler_unit import tvs_pkg::*; #(
  parameter int MAX_DIM   = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_kind,
  input  logic [POS_W-1:0]     in_pos_x,
  input  logic [POS_W-1:0]     in_pos_y,
  input  logic [POS_W-1:0]     in_pos_z,
  input  logic [WIDX_W-1:0]    in_write_x,
  input  logic [WIDX_W-1:0]    in_write_y,
  input  logic [WIDX_W-1:0]    in_write_z,
  input  logic [LEVEL_W-1:0]   in_write_level,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 out_valid,
  output logic [SAMPLE_W-1:0]  out_sample_level
);

  // Half index width of one parity bank per axis.
  localparam int HW = (MAX_DIM > 2) ? $clog2((MAX_DIM + 1) / 2) : 1;
  localparam int AW = 3 * HW;

  logic                      accept;
  logic [SIZE_W-1:0]         size_x_r, size_y_r, size_z_r;
  logic [LEVEL_W-1:0]        bound_r;

  logic                      rd_valid;
  tvs_corner_t               rd_corner;
  logic [2:0][FRAC_BITS-1:0] rd_frac;
  logic [7:0][AW-1:0]        rd_addr;
  logic                      wr_en;
  logic [2:0]                wr_bank;
  logic [AW-1:0]             wr_addr;
  logic [LEVEL_W-1:0]        wr_level;

  logic                      vox_valid;
  tvs_corner_t               vox_corner;
  logic [2:0][FRAC_BITS-1:0] vox_frac;
  logic [7:0][LEVEL_W-1:0]   vox_data;

  // The pipeline never holds off an item.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= 7'd64;
      size_y_r <= 7'd64;
      size_z_r <= 7'd64;
      bound_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SIZE_X: size_x_r <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y: size_y_r <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z: size_z_r <= cfg_data[SIZE_W-1:0];
        REG_BOUND:  bound_r  <= cfg_data[LEVEL_W-1:0];
      endcase
    end
  end

  // Point decode and write decode.
  tvs_addr #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS),
    .HW        (HW)
  ) u_addr (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (accept),
    .in_kind        (in_kind),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_write_x     (in_write_x),
    .in_write_y     (in_write_y),
    .in_write_z     (in_write_z),
    .in_write_level (in_write_level),
    .size_x         (size_x_r),
    .size_y         (size_y_r),
    .size_z         (size_z_r),
    .rd_valid       (rd_valid),
    .rd_corner      (rd_corner),
    .rd_frac        (rd_frac),
    .rd_addr        (rd_addr),
    .wr_en          (wr_en),
    .wr_bank        (wr_bank),
    .wr_addr        (wr_addr),
    .wr_level       (wr_level)
  );

  // Banked voxel store.
  tvs_store #(
    .FRAC_BITS (FRAC_BITS),
    .HW        (HW)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_valid   (rd_valid),
    .rd_corner  (rd_corner),
    .rd_frac    (rd_frac),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .wr_bank    (wr_bank),
    .wr_addr    (wr_addr),
    .wr_level   (wr_level),
    .vox_valid  (vox_valid),
    .vox_corner (vox_corner),
    .vox_frac   (vox_frac),
    .vox_data   (vox_data)
  );

  // Blend and round.
  tvs_lerp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lerp (
    .clk        (clk),
    .rst_n      (rst_n),
    .vox_valid  (vox_valid),
    .vox_corner (vox_corner),
    .vox_frac   (vox_frac),
    .vox_data   (vox_data),
    .bound      (bound_r),
    .out_valid  (out_valid),
    .out_level  (out_sample_level)
  );

  // A sample item yields a result at the end of the pipeline.
  a_sample_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == KIND_SAMPLE)) |-> ##6 out_valid)
    else $error("sample item did not produce a result on time");

  // A write item never yields a result.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == KIND_WRITE)) |-> ##6 !out_valid)
    else $error("write item produced a result");

  // Results stay within the grey-level range.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_level <= OUT_MAX))
    else $error("result above the largest grey level");

  // Reset empties the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule

[hdl/tvs_addr.sv]
// ----------------------------------------------------------------------------
// tvs_addr: point decode stage
// Floors the sample point, checks each neighbour against the configured
// volume and forms one read address per parity bank; decodes voxel writes.
// ----------------------------------------------------------------------------
module tvs_addr import tvs_pkg::*; #(
  parameter int MAX_DIM   = 64,
  parameter int FRAC_BITS = 8,
  parameter int HW        = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_kind,
  input  logic [POS_W-1:0]              in_pos_x,
  input  logic [POS_W-1:0]              in_pos_y,
  input  logic [POS_W-1:0]              in_pos_z,
  input  logic [WIDX_W-1:0]             in_write_x,
  input  logic [WIDX_W-1:0]             in_write_y,
  input  logic [WIDX_W-1:0]             in_write_z,
  input  logic [LEVEL_W-1:0]            in_write_level,
  input  logic [SIZE_W-1:0]             size_x,
  input  logic [SIZE_W-1:0]             size_y,
  input  logic [SIZE_W-1:0]             size_z,
  output logic                          rd_valid,
  output tvs_corner_t                   rd_corner,
  output logic [2:0][FRAC_BITS-1:0]     rd_frac,
  output logic [7:0][3*HW-1:0]          rd_addr,
  output logic                          wr_en,
  output logic [2:0]                    wr_bank,
  output logic [3*HW-1:0]               wr_addr,
  output logic [LEVEL_W-1:0]            wr_level
);

  localparam int AW = 3 * HW;

  logic [POS_W-1:0]         pos_in   [3];
  logic [SIZE_W-1:0]        size_in  [3];
  logic signed [31:0]       pos_ext  [3];
  logic signed [16:0]       lo_c     [3];
  logic signed [16:0]       hi_c     [3];
  logic signed [16:0]       lim      [3];
  logic [HW-1:0]            half_ev  [3];
  logic [HW-1:0]            half_od  [3];
  logic [1:0]               in_vol   [3];
  logic [2:0]               bsel;
  logic                     in_store;

  logic                     rd_valid_r, rd_valid_nxt;
  tvs_corner_t              corner_r, corner_nxt;
  logic [2:0][FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [7:0][AW-1:0]       rd_addr_r, rd_addr_nxt;
  logic                     wr_en_r, wr_en_nxt;
  logic [2:0]               wr_bank_r;
  logic [AW-1:0]            wr_addr_r;
  logic [LEVEL_W-1:0]       wr_level_r;

  assign pos_in[0]  = in_pos_x;
  assign pos_in[1]  = in_pos_y;
  assign pos_in[2]  = in_pos_z;
  assign size_in[0] = size_x;
  assign size_in[1] = size_y;
  assign size_in[2] = size_z;

  // Per axis: floor, fraction, neighbour range checks and bank half indexes.
  // The even bank holds the lower neighbour when the base is even and the
  // upper one when it is odd; in both cases its half index is (base+1)/2.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_ext[i]  = 32'(signed'(pos_in[i]));
      lo_c[i]     = 17'(pos_ext[i] >>> FRAC_BITS);
      hi_c[i]     = lo_c[i] + 17'sd1;
      lim[i]      = (17'(size_in[i]) > 17'(MAX_DIM)) ? 17'(MAX_DIM) : 17'(size_in[i]);
      in_vol[i][0] = (lo_c[i] >= 17'sd0) && (lo_c[i] < lim[i]);
      in_vol[i][1] = (hi_c[i] >= 17'sd0) && (hi_c[i] < lim[i]);
      half_ev[i]  = HW'(hi_c[i] >>> 1);
      half_od[i]  = HW'(lo_c[i] >>> 1);
      frac_nxt[i] = pos_ext[i][FRAC_BITS-1:0];
    end
  end

  // One read address per parity bank, {z, y, x} half indexes.
  always_comb begin
    bsel = 3'd0;
    for (int b = 0; b < 8; b++) begin
      bsel = 3'(b);
      rd_addr_nxt[b] = {bsel[2] ? half_od[2] : half_ev[2],
                        bsel[1] ? half_od[1] : half_ev[1],
                        bsel[0] ? half_od[0] : half_ev[0]};
    end
  end

  always_comb begin
    corner_nxt.parity = {lo_c[2][0], lo_c[1][0], lo_c[0][0]};
    corner_nxt.vx     = in_vol[0];
    corner_nxt.vy     = in_vol[1];
    corner_nxt.vz     = in_vol[2];
  end

  // Writes with an index beyond the store are dropped.
  assign in_store = (11'(in_write_x) < 11'(MAX_DIM)) &&
                    (11'(in_write_y) < 11'(MAX_DIM)) &&
                    (11'(in_write_z) < 11'(MAX_DIM));

  assign rd_valid_nxt = in_valid && (in_kind == KIND_SAMPLE);
  assign wr_en_nxt    = in_valid && (in_kind == KIND_WRITE) && in_store;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      wr_en_r    <= 1'b0;
    end else begin
      rd_valid_r <= rd_valid_nxt;
      wr_en_r    <= wr_en_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    corner_r   <= corner_nxt;
    frac_r     <= frac_nxt;
    rd_addr_r  <= rd_addr_nxt;
    wr_bank_r  <= {in_write_z[0], in_write_y[0], in_write_x[0]};
    wr_addr_r  <= {HW'(in_write_z >> 1), HW'(in_write_y >> 1), HW'(in_write_x >> 1)};
    wr_level_r <= in_write_level;
  end

  assign rd_valid  = rd_valid_r;
  assign rd_corner = corner_r;
  assign rd_frac   = frac_r;
  assign rd_addr   = rd_addr_r;
  assign wr_en     = wr_en_r;
  assign wr_bank   = wr_bank_r;
  assign wr_addr   = wr_addr_r;
  assign wr_level  = wr_level_r;

endmodule

[hdl/tvs_store.sv]
// ----------------------------------------------------------------------------
// tvs_store: parity-banked voxel store
// Eight banks selected by the parity of x, y and z; each bank takes one
// write and one read a cycle, so all eight neighbours come out together.
// ----------------------------------------------------------------------------
module tvs_store import tvs_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int HW        = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_valid,
  input  tvs_corner_t                   rd_corner,
  input  logic [2:0][FRAC_BITS-1:0]     rd_frac,
  input  logic [7:0][3*HW-1:0]          rd_addr,
  input  logic                          wr_en,
  input  logic [2:0]                    wr_bank,
  input  logic [3*HW-1:0]               wr_addr,
  input  logic [LEVEL_W-1:0]            wr_level,
  output logic                          vox_valid,
  output tvs_corner_t                   vox_corner,
  output logic [2:0][FRAC_BITS-1:0]     vox_frac,
  output logic [7:0][LEVEL_W-1:0]       vox_data
);

  localparam int AW    = 3 * HW;
  localparam int DEPTH = 1 << AW;

  logic                      valid_r;
  tvs_corner_t               corner_r;
  logic [2:0][FRAC_BITS-1:0] frac_r;

  // Banks: write port and registered read port.
  for (genvar g = 0; g < 8; g++) begin : g_bank
    logic [LEVEL_W-1:0] mem_r [DEPTH];
    logic [LEVEL_W-1:0] q_r;

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 3'(g))) begin
        mem_r[wr_addr] <= wr_level;
      end
      q_r <= mem_r[rd_addr[g]];
    end

    assign vox_data[g] = q_r;
  end

  // Sideband travels alongside the read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    corner_r <= rd_corner;
    frac_r   <= rd_frac;
  end

  assign vox_valid  = valid_r;
  assign vox_corner = corner_r;
  assign vox_frac   = frac_r;

endmodule

[hdl/tvs_lerp.sv]
// ----------------------------------------------------------------------------
// tvs_lerp: interpolation pipeline
// Picks the eight corners from the banks, blends along x, y and z in three
// registered stages at full precision, then rounds half up and saturates, or widens.
// ----------------------------------------------------------------------------
module tvs_lerp import tvs_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vox_valid,
  input  tvs_corner_t                   vox_corner,
  input  logic [2:0][FRAC_BITS-1:0]     vox_frac,
  input  logic [7:0][LEVEL_W-1:0]       vox_data,
  input  logic [LEVEL_W-1:0]            bound,
  output logic                          out_valid,
  output logic [SAMPLE_W-1:0]           out_level
);

  localparam int F  = FRAC_BITS;
  localparam int W1 = LEVEL_W + F;
  localparam int W2 = LEVEL_W + 2 * F;
  localparam int W3 = LEVEL_W + 3 * F;

  logic [2:0]          bank_lo, bank_hi;
  logic [LEVEL_W-1:0]  va, vb;
  logic [F:0]          wx, wy, wz;
  logic [1:0]          jsel;

  logic                v1_r, v2_r, v3_r, out_valid_r;
  logic [3:0][W1-1:0]  cx_r, cx_nxt;
  logic [1:0][W2-1:0]  cy_r, cy_nxt;
  logic [W3-1:0]       total_r, total_nxt;
  logic [F-1:0]        fy1_r, fz1_r, fz2_r;
  logic [SAMPLE_W-1:0] level_r, level_nxt;

  // Stage x: corner pick and blend along x, one result per (y, z) pair.
  always_comb begin
    wx      = {1'b1, {F{1'b0}}} - {1'b0, vox_frac[0]};
    jsel    = 2'd0;
    bank_lo = 3'd0;
    bank_hi = 3'd0;
    va      = '0;
    vb      = '0;
    for (int j = 0; j < 4; j++) begin
      jsel    = 2'(j);
      bank_lo = {vox_corner.parity[2] ^ jsel[1], vox_corner.parity[1] ^ jsel[0],
                 vox_corner.parity[0]};
      bank_hi = {bank_lo[2:1], ~bank_lo[0]};
      va = (vox_corner.vx[0] && vox_corner.vy[jsel[0]] && vox_corner.vz[jsel[1]]) ?
           vox_data[bank_lo] : bound;
      vb = (vox_corner.vx[1] && vox_corner.vy[jsel[0]] && vox_corner.vz[jsel[1]]) ?
           vox_data[bank_hi] : bound;
      cx_nxt[j] = W1'(va) * W1'(wx) + W1'(vb) * W1'(vox_frac[0]);
    end
  end

  // Stage y: blend along y for both z planes.
  always_comb begin
    wy        = {1'b1, {F{1'b0}}} - {1'b0, fy1_r};
    cy_nxt[0] = W2'(cx_r[0]) * W2'(wy) + W2'(cx_r[1]) * W2'(fy1_r);
    cy_nxt[1] = W2'(cx_r[2]) * W2'(wy) + W2'(cx_r[3]) * W2'(fy1_r);
  end

  // Stage z: final blend, 3*F fraction bits.
  always_comb begin
    wz        = {1'b1, {F{1'b0}}} - {1'b0, fz2_r};
    total_nxt = W3'(cy_r[0]) * W3'(wz) + W3'(cy_r[1]) * W3'(fz2_r);
  end

  // Output stage: round half up to 8 fraction bits, or widen when shorter.
  if (3 * F > OUT_FRAC) begin : g_round
    localparam int S = 3 * F - OUT_FRAC;
    logic [W3:0] biased;
    logic [W3:0] rounded;

    always_comb begin
      biased    = {1'b0, total_r} + ({{W3{1'b0}}, 1'b1} << (S - 1));
      rounded   = biased >> S;
      level_nxt = (rounded > (W3 + 1)'(OUT_MAX)) ? OUT_MAX : SAMPLE_W'(rounded);
    end
  end else begin : g_widen
    always_comb begin
      level_nxt = SAMPLE_W'(total_r) << (OUT_FRAC - 3 * F);
    end
  end

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= vox_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // Data of the four stages, fractions delayed to meet their stage.
  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    fy1_r   <= vox_frac[1];
    fz1_r   <= vox_frac[2];
    cy_r    <= cy_nxt;
    fz2_r   <= fz1_r;
    total_r <= total_nxt;
    level_r <= level_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_level = level_r;

endmodule
